/* src/ir_pulse_distance_receiver_core_assert.svh */
// Assertion macros used by the receiver top level.
`ifndef IR_PULSE_DISTANCE_RECEIVER_CORE_ASSERT_SVH
`define IR_PULSE_DISTANCE_RECEIVER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IRD_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("receiver assertion failed");
`define IRD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("receiver assertion failed");
`else
`define IRD_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define IRD_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

/* src/ird_pkg.sv */
// Types and constants of the pulse-distance IR receiver.
`default_nettype none
package ird_pkg;

    localparam int MAX_BYTES   = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W      = 5;

    typedef enum logic [1:0] {
        ACT_ARM,
        ACT_EDGE,
        ACT_WAIT,
        ACT_SCAN_END
    } t_action;

    typedef enum logic [2:0] {
        CL_JUNK,
        CL_LONG,
        CL_BITM,
        CL_D0,
        CL_D1,
        CL_HELLO,
        CL_BEGIN
    } t_class;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SCAN,
        PH_PRE,
        PH_MARK,
        PH_DARK
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_DONE,
        KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        ERR_MID_MESSAGE,
        ERR_SCAN_TIMEOUT,
        ERR_PREAMBLE,
        ERR_BIT_MARK,
        ERR_BIT_DARK,
        ERR_INCOMPLETE,
        ERR_OVERFLOW
    } t_err;

    typedef enum logic [2:0] {
        REG_DARK_MIN,
        REG_DARK_MAX,
        REG_BIT0_DARK_MAX,
        REG_BIT1_DARK_MAX,
        REG_HELLO_DARK_MAX,
        REG_MARK_MIN,
        REG_MARK_MAX,
        REG_LONG_MARK
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] dark_min;
        logic [15:0] dark_max;
        logic [15:0] bit0_dark_max;
        logic [15:0] bit1_dark_max;
        logic [15:0] hello_dark_max;
        logic [15:0] mark_min;
        logic [15:0] mark_max;
        logic [15:0] long_mark;
    } t_thresholds;

    typedef struct packed {
        t_action    action;
        t_class     cls;
        logic [6:0] capacity;
    } t_queue_word;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage
`default_nettype wire

/* src/ird_regs.sv */
// Threshold register file behind the APB port.
`default_nettype none
module ird_regs
    import ird_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_thresholds            o_thr
);

    t_thresholds r_thr;
    t_reg_idx    w_idx;
    logic [15:0] w_rd;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;
    assign o_thr  = r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.dark_min       <= 16'd40;
            r_thr.dark_max       <= 16'd1400;
            r_thr.bit0_dark_max  <= 16'd170;
            r_thr.bit1_dark_max  <= 16'd420;
            r_thr.hello_dark_max <= 16'd680;
            r_thr.mark_min       <= 16'd40;
            r_thr.mark_max       <= 16'd2000;
            r_thr.long_mark      <= 16'd90;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_DARK_MIN:       r_thr.dark_min       <= pwdata[15:0];
                REG_DARK_MAX:       r_thr.dark_max       <= pwdata[15:0];
                REG_BIT0_DARK_MAX:  r_thr.bit0_dark_max  <= pwdata[15:0];
                REG_BIT1_DARK_MAX:  r_thr.bit1_dark_max  <= pwdata[15:0];
                REG_HELLO_DARK_MAX: r_thr.hello_dark_max <= pwdata[15:0];
                REG_MARK_MIN:       r_thr.mark_min       <= pwdata[15:0];
                REG_MARK_MAX:       r_thr.mark_max       <= pwdata[15:0];
                REG_LONG_MARK:      r_thr.long_mark      <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DARK_MIN:       w_rd = r_thr.dark_min;
            REG_DARK_MAX:       w_rd = r_thr.dark_max;
            REG_BIT0_DARK_MAX:  w_rd = r_thr.bit0_dark_max;
            REG_BIT1_DARK_MAX:  w_rd = r_thr.bit1_dark_max;
            REG_HELLO_DARK_MAX: w_rd = r_thr.hello_dark_max;
            REG_MARK_MIN:       w_rd = r_thr.mark_min;
            REG_MARK_MAX:       w_rd = r_thr.mark_max;
            REG_LONG_MARK:      w_rd = r_thr.long_mark;
        endcase
    end

    assign prdata = {16'd0, w_rd};

endmodule
`default_nettype wire

/* src/ird_front.sv */
// Front end: classifies each incoming event into a queue word.
`default_nettype none
module ird_front
    import ird_pkg::*;
(
    input  wire logic [1:0]  i_action,
    input  wire logic        i_level_is_mark,
    input  wire logic [15:0] i_period_us,
    input  wire logic [6:0]  i_capacity,
    input  t_thresholds      i_thr,
    output t_queue_word      o_word
);

    t_class     w_cls;
    logic [6:0] w_cap;

    always_comb begin
        w_cls = CL_JUNK;
        if (t_action'(i_action) == ACT_EDGE) begin
            if (i_level_is_mark) begin
                if (i_period_us < i_thr.dark_min || i_period_us > i_thr.dark_max) begin
                    w_cls = CL_JUNK;
                end else if (i_period_us < i_thr.bit0_dark_max) begin
                    w_cls = CL_D0;
                end else if (i_period_us < i_thr.bit1_dark_max) begin
                    w_cls = CL_D1;
                end else if (i_period_us < i_thr.hello_dark_max) begin
                    w_cls = CL_HELLO;
                end else begin
                    w_cls = CL_BEGIN;
                end
            end else begin
                if (i_period_us < i_thr.mark_min || i_period_us > i_thr.mark_max) begin
                    w_cls = CL_JUNK;
                end else if (i_period_us < i_thr.long_mark) begin
                    w_cls = CL_BITM;
                end else begin
                    w_cls = CL_LONG;
                end
            end
        end
    end

    assign w_cap = ({1'b0, i_capacity} > 8'(MAX_BYTES)) ? 7'(MAX_BYTES) : i_capacity;

    assign o_word.action   = t_action'(i_action);
    assign o_word.cls      = w_cls;
    assign o_word.capacity = w_cap;

endmodule
`default_nettype wire

/* src/ird_queue.sv */
// Short queue of classified words between front end and framer.
`default_nettype none
module ird_queue
    import ird_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_queue_word i_word,
    input  wire logic   i_pop,
    output t_queue_word o_word,
    output t_queue_status o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_queue_word r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_word       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

endmodule
`default_nettype wire

/* src/ird_framer.sv */
// Back end: message framer with its registered result word.
`default_nettype none
module ird_framer
    import ird_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_queue_word i_word,
    input  wire logic   i_empty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic [6:0]  o_byte_index,
    output logic [2:0]  o_error_code
);

    t_phase     r_phase, n_phase;
    logic [2:0] r_bit_pos, n_bit_pos;
    logic [6:0] r_count, n_count;
    logic [7:0] r_byte, n_byte;
    logic [6:0] r_cap, n_cap;
    logic       r_out_valid, n_out_valid;
    t_kind      r_kind, n_kind;
    logic [7:0] r_value, n_value;
    logic [6:0] r_index, n_index;
    t_err       r_err, n_err;

    logic       w_emit;
    t_kind      w_kind;
    logic [7:0] w_value;
    logic [6:0] w_index;
    t_err       w_err;
    logic [7:0] w_byte;

    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_pos   <= 3'd7;
            r_count     <= '0;
            r_byte      <= '0;
            r_cap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_bit_pos   <= n_bit_pos;
            r_count     <= n_count;
            r_byte      <= n_byte;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_value <= n_value;
        r_index <= n_index;
        r_err   <= n_err;
    end

    always_comb begin
        n_phase   = r_phase;
        n_bit_pos = r_bit_pos;
        n_count   = r_count;
        n_byte    = r_byte;
        n_cap     = r_cap;
        w_emit    = 1'b0;
        w_kind    = KIND_ERROR;
        w_value   = '0;
        w_index   = r_count;
        w_err     = ERR_MID_MESSAGE;
        w_byte    = r_byte;
        w_byte[r_bit_pos] = r_byte[r_bit_pos] | (i_word.cls == CL_D1);

        if (o_pop) begin
            if (i_word.action == ACT_ARM) begin
                n_cap     = i_word.capacity;
                n_phase   = PH_SCAN;
                n_bit_pos = 3'd7;
                n_count   = '0;
                n_byte    = '0;
            end else if (r_phase != PH_IDLE) begin
                if (i_word.action == ACT_SCAN_END) begin
                    if (r_phase == PH_SCAN) begin
                        w_emit  = 1'b1;
                        w_err   = ERR_SCAN_TIMEOUT;
                        n_phase = PH_IDLE;
                    end
                end else if (!(i_word.action == ACT_WAIT && r_phase == PH_SCAN)) begin
                    unique case (r_phase)
                        PH_SCAN: begin
                            if (i_word.cls == CL_LONG || i_word.cls == CL_BITM) begin
                                n_phase = PH_PRE;
                            end else if (i_word.cls == CL_D0 || i_word.cls == CL_D1) begin
                                w_emit  = 1'b1;
                                w_err   = ERR_MID_MESSAGE;
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_PRE: begin
                            if (i_word.cls == CL_HELLO || i_word.cls == CL_BEGIN) begin
                                n_phase   = PH_MARK;
                                n_bit_pos = 3'd7;
                                n_count   = '0;
                                n_byte    = '0;
                            end else begin
                                w_emit  = 1'b1;
                                w_err   = ERR_PREAMBLE;
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_MARK: begin
                            if (i_word.cls == CL_LONG) begin
                                w_emit  = 1'b1;
                                n_phase = PH_IDLE;
                                if (r_bit_pos != 3'd7) begin
                                    w_err = ERR_INCOMPLETE;
                                end else begin
                                    w_kind = KIND_DONE;
                                end
                            end else if (i_word.cls == CL_BITM) begin
                                n_phase = PH_DARK;
                            end else begin
                                w_emit  = 1'b1;
                                w_err   = ERR_BIT_MARK;
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_DARK: begin
                            if (i_word.cls != CL_D0 && i_word.cls != CL_D1) begin
                                w_emit  = 1'b1;
                                w_err   = ERR_BIT_DARK;
                                n_phase = PH_IDLE;
                            end else if (r_count >= r_cap) begin
                                w_emit  = 1'b1;
                                w_err   = ERR_OVERFLOW;
                                n_phase = PH_IDLE;
                            end else begin
                                n_phase = PH_MARK;
                                if (r_bit_pos == 3'd0) begin
                                    w_emit    = 1'b1;
                                    w_kind    = KIND_BYTE;
                                    w_value   = w_byte;
                                    n_bit_pos = 3'd7;
                                    n_byte    = '0;
                                    n_count   = r_count + 1'b1;
                                end else begin
                                    n_byte    = w_byte;
                                    n_bit_pos = r_bit_pos - 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
        end

        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_value     = r_value;
        n_index     = r_index;
        n_err       = r_err;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_kind      = w_kind;
            n_value     = w_value;
            n_index     = w_index;
            n_err       = (w_kind == KIND_ERROR) ? w_err : ERR_MID_MESSAGE;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_byte_value = r_value;
    assign o_byte_index = r_index;
    assign o_error_code = r_err;

endmodule
`default_nettype wire

/* src/ir_pulse_distance_receiver_core.sv */
// Top level of the pulse-distance IR receiver.
//
//   channel   direction  handshake                word
//   in        input      i_in_valid / o_in_stall  action, level, period, capacity
//   out       output     o_out_valid / i_out_stall kind, byte, index, error code
//   config    input      APB psel/penable/pwrite  eight 16-bit thresholds
//
// One event word is accepted per cycle unless the queue is full. Its result, if any,
// passes the queue and the framer into the registered result word, held while stalled.
// The queue holds FIFO_DEPTH words, so the input stalls only when it is full.
// Reset is synchronous and active low and loads the default thresholds.
`default_nettype none
`include "ir_pulse_distance_receiver_core_assert.svh"
module ir_pulse_distance_receiver_core
    import ird_pkg::*;
#(
    parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_action,
    input  wire logic              i_level_is_mark,
    input  wire logic [15:0]       i_period_us,
    input  wire logic [6:0]        i_capacity,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_byte_value,
    output logic [6:0]             o_byte_index,
    output logic [2:0]             o_error_code,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    t_thresholds   w_thr;
    t_queue_word   w_in_word;
    t_queue_word   w_head;
    t_queue_status w_stat;
    logic          w_push;
    logic          w_pop;
    logic          w_byte_out;

    assign o_in_stall = w_stat.full;
    assign w_push     = i_in_valid && !w_stat.full;
    assign w_byte_out = o_out_valid && (o_kind == KIND_BYTE);

    ird_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_thr   (w_thr)
    );

    ird_front u_front (
        .i_action        (i_action),
        .i_level_is_mark (i_level_is_mark),
        .i_period_us     (i_period_us),
        .i_capacity      (i_capacity),
        .i_thr           (w_thr),
        .o_word          (w_in_word)
    );

    ird_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_in_word),
        .i_pop   (w_pop),
        .o_word  (w_head),
        .o_stat  (w_stat)
    );

    ird_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (w_head),
        .i_empty      (w_stat.empty),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_byte_value (o_byte_value),
        .o_byte_index (o_byte_index),
        .o_error_code (o_error_code)
    );

    `IRD_ASSERT_IMP(a_queue_sane, i_clk, i_rst_n, w_stat.full, !w_stat.empty)
    `IRD_ASSERT_IMP(a_no_pop_on_stall, i_clk, i_rst_n, o_out_valid && i_out_stall, !w_pop)
    `IRD_ASSERT_IMP(a_byte_no_error, i_clk, i_rst_n, w_byte_out, o_error_code == ERR_MID_MESSAGE)
    `IRD_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, w_push, !w_stat.empty)

endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the pulse-distance IR receiver core.
`timescale 1ns / 1ps
module tb;
    import ird_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SET  = 120;

    // The error field reads zero on byte and done words.
    localparam t_err NO_ERROR = ERR_MID_MESSAGE;

    typedef struct {
        t_kind      kind;
        logic [7:0] value;
        logic [6:0] index;
        t_err       code;
    } t_decoded;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action = '0;
    logic        i_level_is_mark = 1'b0;
    logic [15:0] i_period_us = '0;
    logic [6:0]  i_capacity = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_byte_value;
    logic [6:0]  o_byte_index;
    logic [2:0]  o_error_code;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] reset_thr [8] = '{16'd40, 16'd1400, 16'd170, 16'd420, 16'd680,
                                   16'd40, 16'd2000, 16'd90};
    logic [15:0] thr [8];
    t_phase      frame_phase = PH_IDLE;
    logic [2:0]  bit_pos = 3'd7;
    logic [6:0]  byte_cnt = '0;
    logic [7:0]  shift_byte = '0;
    logic [6:0]  armed_cap = '0;

    t_decoded    decoded_q [$];
    int          items_sent = 0;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 30;
    int          recv_stall_pct = 66;

    ir_pulse_distance_receiver_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_level_is_mark (i_level_is_mark),
        .i_period_us     (i_period_us),
        .i_capacity      (i_capacity),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_byte_value    (o_byte_value),
        .o_byte_index    (o_byte_index),
        .o_error_code    (o_error_code),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic t_class classify_period(logic is_mark, logic [15:0] d);
        if (is_mark) begin
            if (d < thr[REG_DARK_MIN] || d > thr[REG_DARK_MAX]) return CL_JUNK;
            if (d < thr[REG_BIT0_DARK_MAX]) return CL_D0;
            if (d < thr[REG_BIT1_DARK_MAX]) return CL_D1;
            if (d < thr[REG_HELLO_DARK_MAX]) return CL_HELLO;
            return CL_BEGIN;
        end
        if (d < thr[REG_MARK_MIN] || d > thr[REG_MARK_MAX]) return CL_JUNK;
        if (d < thr[REG_LONG_MARK]) return CL_BITM;
        return CL_LONG;
    endfunction

    function automatic void push_word(t_kind kind, logic [7:0] value, logic [6:0] index,
                                      t_err code);
        t_decoded w;
        w.kind = kind;
        w.value = value;
        w.index = index;
        w.code = code;
        decoded_q.push_back(w);
    endfunction

    function automatic void abort_frame(t_err code);
        frame_phase = PH_IDLE;
        push_word(KIND_ERROR, 8'd0, byte_cnt, code);
    endfunction

    function automatic void decode_event(t_action act, logic lvl, logic [15:0] per,
                                         logic [6:0] cap);
        t_class cls;
        if (act == ACT_ARM) begin
            armed_cap = (cap > MAX_BYTES) ? 7'(MAX_BYTES) : cap;
            frame_phase = PH_SCAN;
            bit_pos = 3'd7;
            byte_cnt = '0;
            shift_byte = '0;
            return;
        end
        if (frame_phase == PH_IDLE) return;
        if (act == ACT_SCAN_END) begin
            if (frame_phase == PH_SCAN) abort_frame(ERR_SCAN_TIMEOUT);
            return;
        end
        if (act == ACT_WAIT) begin
            if (frame_phase == PH_SCAN) return;
            cls = CL_JUNK;
        end else begin
            cls = classify_period(lvl, per);
        end
        case (frame_phase)
            PH_SCAN: begin
                if (cls inside {CL_LONG, CL_BITM}) frame_phase = PH_PRE;
                else if (cls inside {CL_D0, CL_D1}) abort_frame(ERR_MID_MESSAGE);
            end
            PH_PRE: begin
                if (cls inside {CL_HELLO, CL_BEGIN}) begin
                    frame_phase = PH_MARK;
                    bit_pos = 3'd7;
                    byte_cnt = '0;
                    shift_byte = '0;
                end else begin
                    abort_frame(ERR_PREAMBLE);
                end
            end
            PH_MARK: begin
                if (cls == CL_LONG) begin
                    if (bit_pos != 3'd7) begin
                        abort_frame(ERR_INCOMPLETE);
                    end else begin
                        frame_phase = PH_IDLE;
                        push_word(KIND_DONE, 8'd0, byte_cnt, NO_ERROR);
                    end
                end else if (cls == CL_BITM) begin
                    frame_phase = PH_DARK;
                end else begin
                    abort_frame(ERR_BIT_MARK);
                end
            end
            PH_DARK: begin
                if (!(cls inside {CL_D0, CL_D1})) begin
                    abort_frame(ERR_BIT_DARK);
                end else if (byte_cnt >= armed_cap) begin
                    abort_frame(ERR_OVERFLOW);
                end else begin
                    frame_phase = PH_MARK;
                    if (cls == CL_D1) shift_byte[bit_pos] = 1'b1;
                    if (bit_pos == 3'd0) begin
                        push_word(KIND_BYTE, shift_byte, byte_cnt, NO_ERROR);
                        bit_pos = 3'd7;
                        shift_byte = '0;
                        byte_cnt = byte_cnt + 7'd1;
                    end else begin
                        bit_pos = bit_pos - 3'd1;
                    end
                end
            end
            default: frame_phase = PH_IDLE;
        endcase
    endfunction

    function automatic logic [15:0] pick_period(logic lvl, t_class want);
        logic [15:0] cand;
        for (int tries = 0; tries < 200; tries++) begin
            case ($urandom_range(3))
                0: cand = 16'($urandom);
                1: cand = thr[$urandom_range(7)] + 16'($urandom_range(4)) - 16'd2;
                2: cand = 16'($urandom_range(2100));
                default: cand = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            endcase
            if (classify_period(lvl, cand) == want) return cand;
        end
        return 16'($urandom);
    endfunction

    always @(posedge i_clk) begin : check_words
        t_decoded want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected word: kind %0d index %0d", o_kind, o_byte_index);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                compare_field("kind", want.kind, o_kind);
                compare_field("byte_value", want.value, o_byte_value);
                compare_field("byte_index", want.index, o_byte_index);
                compare_field("error_code", want.code, o_error_code);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_event(t_action act, logic lvl, logic [15:0] per, logic [6:0] cap);
        int gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_level_is_mark <= lvl;
        i_period_us <= per;
        i_capacity <= cap;
        do @(posedge i_clk); while (o_in_stall);
        decode_event(act, lvl, per, cap);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(t_reg_idx idx, logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        thr[idx] = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        compare_field("prdata", value, prdata[15:0]);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_thresholds(int set);
        logic [15:0] vals [8];
        case (set)
            0: vals = reset_thr;
            1: vals = '{default: 16'h0000};
            2: vals = '{default: 16'hFFFF};
            3: begin
                vals[REG_DARK_MIN] = 16'($urandom_range(100));
                vals[REG_BIT0_DARK_MAX] = vals[REG_DARK_MIN] + 16'($urandom_range(1, 300));
                vals[REG_BIT1_DARK_MAX] = vals[REG_BIT0_DARK_MAX] + 16'($urandom_range(1, 300));
                vals[REG_HELLO_DARK_MAX] = vals[REG_BIT1_DARK_MAX] + 16'($urandom_range(1, 300));
                vals[REG_DARK_MAX] = vals[REG_HELLO_DARK_MAX] + 16'($urandom_range(1000));
                vals[REG_MARK_MIN] = 16'($urandom_range(100));
                vals[REG_LONG_MARK] = vals[REG_MARK_MIN] + 16'($urandom_range(1, 200));
                vals[REG_MARK_MAX] = vals[REG_LONG_MARK] + 16'($urandom_range(2000));
            end
            default: foreach (vals[k]) vals[k] = 16'($urandom);
        endcase
        for (int k = 0; k < 8; k++) write_threshold(t_reg_idx'(k), vals[k]);
    endtask

    task automatic send_edge(logic lvl, logic [15:0] per);
        send_event(ACT_EDGE, lvl, per, 7'($urandom));
    endtask

    task automatic send_noise();
        send_event(t_action'($urandom_range(3)), 1'($urandom), 16'($urandom), 7'($urandom));
    endtask

    task automatic send_scan_filler();
        case ($urandom_range(3))
            0: send_event(ACT_WAIT, 1'($urandom), 16'($urandom), 7'($urandom));
            1: send_edge(1'b1, pick_period(1'b1, $urandom_range(1) ? CL_JUNK : CL_HELLO));
            2: send_edge(1'b1, pick_period(1'b1, CL_BEGIN));
            default: send_edge(1'b0, pick_period(1'b0, CL_JUNK));
        endcase
    endtask

    task automatic send_random_message();
        int n_bytes;
        int n_bits;
        logic [6:0] cap;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4)) send_noise();
            return;
        end
        n_bytes = ($urandom_range(9) == 0) ? $urandom_range(4, 9) : $urandom_range(3);
        n_bits = n_bytes * 8;
        if ($urandom_range(9) == 0) n_bits += $urandom_range(1, 7);
        case ($urandom_range(9))
            0: cap = 7'($urandom);
            1: cap = (n_bytes > 0) ? 7'($urandom_range(n_bytes - 1)) : 7'd0;
            default: cap = 7'(n_bytes + $urandom_range(2));
        endcase
        send_event(ACT_ARM, 1'($urandom), 16'($urandom), cap);
        repeat ($urandom_range(2)) send_scan_filler();
        send_edge(1'b0, pick_period(1'b0, $urandom_range(1) ? CL_LONG : CL_BITM));
        send_edge(1'b1, pick_period(1'b1, $urandom_range(1) ? CL_HELLO : CL_BEGIN));
        for (int b = 0; b < n_bits; b++) begin
            if ($urandom_range(99) < 2) send_noise();
            send_edge(1'b0, pick_period(1'b0, CL_BITM));
            send_edge(1'b1, pick_period(1'b1, $urandom_range(1) ? CL_D1 : CL_D0));
        end
        send_edge(1'b0, pick_period(1'b0, CL_LONG));
    endtask

    task automatic test_idle_events();
        send_event(ACT_SCAN_END, 1'b0, 16'h0000, 7'd0);
        send_event(ACT_EDGE, 1'b1, 16'h0000, 7'd0);
        send_event(ACT_WAIT, 1'b0, 16'hFFFF, 7'd127);
    endtask

    task automatic test_scan_timeout();
        send_event(ACT_ARM, 1'b1, 16'hFFFF, 7'd127);
        send_event(ACT_WAIT, 1'b0, 16'd0, 7'd0);
        send_edge(1'b0, 16'hFFFF);
        send_edge(1'b1, 16'hFFFF);
        send_edge(1'b1, 16'd500);
        send_edge(1'b1, 16'd1400);
        send_event(ACT_SCAN_END, 1'b0, 16'd0, 7'd0);
    endtask

    task automatic test_mid_message();
        send_event(ACT_ARM, 1'b0, 16'd0, 7'd64);
        send_edge(1'b1, 16'd40);
    endtask

    task automatic test_overflow_after_rearm();
        send_event(ACT_ARM, 1'b0, 16'd0, 7'd5);
        send_edge(1'b0, 16'd60);
        send_edge(1'b1, 16'd1000);
        send_event(ACT_SCAN_END, 1'b0, 16'd0, 7'd0);
        send_event(ACT_ARM, 1'b0, 16'd0, 7'd0);
        send_edge(1'b0, 16'd89);
        send_edge(1'b1, 16'd679);
        send_edge(1'b0, 16'd40);
        send_edge(1'b1, 16'd169);
    endtask

    task automatic test_empty_message();
        send_event(ACT_ARM, 1'b0, 16'd0, 7'd1);
        send_edge(1'b0, 16'd2000);
        send_edge(1'b1, 16'd680);
        send_edge(1'b0, 16'd90);
    endtask

    task automatic test_bad_preamble();
        send_event(ACT_ARM, 1'b0, 16'd0, 7'd2);
        send_edge(1'b0, 16'd60);
        send_event(ACT_WAIT, 1'b1, 16'd300, 7'd0);
    endtask

    task automatic test_random_traffic();
        int target;
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 66 : 0;
            recv_stall_pct = (mode == 0) ? 66 : (mode == 1) ? 30 : 0;
            for (int set = 0; set < 5; set++) begin
                settle();
                load_thresholds(set);
                target = items_sent + ITEMS_PER_SET;
                while (items_sent < target) send_random_message();
            end
        end
        settle();
    endtask

    initial begin
        thr = reset_thr;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_idle_events();
        test_scan_timeout();
        test_mid_message();
        test_overflow_after_rearm();
        test_empty_message();
        test_bad_preamble();
        test_random_traffic();
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
